### rtl/sid_pkg.sv
// Shared package for the shuffled ID dispenser: widths, command and status codes,
// and the item and divider command structs. No dependencies.
`default_nettype none

package sid_pkg;

   localparam int TABLE_SIZE = 1024;
   localparam int IDX_W      = $clog2(TABLE_SIZE);   // table address / position width
   localparam int ID_W       = IDX_W + 1;            // identifiers 1..TABLE_SIZE, count N
   localparam int RAND_W     = 31;
   localparam int CMD_W      = 2;
   localparam int STAT_W     = 2;
   localparam int STEP_W     = $clog2(RAND_W);       // serial divider step counter

   localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SHUFFLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd2;

   localparam logic [STAT_W-1:0] STAT_DRAWN   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_STARTED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SHUFFLED = 2'd2;
   localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [RAND_W-1:0] rand_a;
      logic [RAND_W-1:0] rand_b;
   } sid_req_type;

   typedef struct packed {
      logic [ID_W-1:0]   id_value;
      logic [STAT_W-1:0] status;
   } sid_rsp_type;

   // launch command for one serial remainder lane
   typedef struct packed {
      logic              start;
      logic [RAND_W-1:0] dividend;
      logic [ID_W-1:0]   divisor;
   } rem_cmd_type;

endpackage

`default_nettype wire

### rtl/sid_rem_unit.sv
// Bit-serial restoring remainder: dividend mod divisor, one dividend bit per cycle.
// Depends on sid_pkg.
`default_nettype none

module sid_rem_unit
   import sid_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rem_cmd_type       cmd,
   output logic                   done,
   output logic [IDX_W-1:0]       remainder
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RAND_W - 1);

   logic [RAND_W-1:0] dvd_ff;
   logic [ID_W-1:0]   divisor_ff;
   logic [IDX_W-1:0]  rem_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [ID_W-1:0]   trial;
   logic [ID_W-1:0]   diff;
   logic [IDX_W-1:0]  rem_in;

   // remainder stays below the divisor, so the restored value fits IDX_W bits
   assign trial  = {rem_ff, dvd_ff[RAND_W-1]};
   assign diff   = trial - divisor_ff;
   assign rem_in = (trial >= divisor_ff) ? diff[IDX_W-1:0] : trial[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff    <= 1'b1;
            step_ff    <= '0;
            dvd_ff     <= cmd.dividend;
            divisor_ff <= cmd.divisor;
            rem_ff     <= '0;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            dvd_ff  <= {dvd_ff[RAND_W-2:0], 1'b0};
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### rtl/sid_seq.sv
// Command sequencer and identifier table: fill, Sattolo step, draw with half-table swap.
// Depends on sid_pkg; drives the three sid_rem_unit lanes.
`default_nettype none

module sid_seq
   import sid_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [ID_W-1:0]   id_count,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sid_req_type       req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sid_rsp_type            rsp_data,
   output rem_cmd_type            rem_a_cmd,
   output rem_cmd_type            rem_b_cmd,
   output rem_cmd_type            rem_c_cmd,
   input  wire logic              rem_done,
   input  wire logic [IDX_W-1:0]  rem_a,
   input  wire logic [IDX_W-1:0]  rem_b,
   input  wire logic [IDX_W-1:0]  rem_c
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_FILL, ST_DIVIDE, ST_SW_RA, ST_SW_RB, ST_SW_WA, ST_SW_WB, ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [CMD_W-1:0]  cmd_ff;
   logic [IDX_W-1:0]  sp_ff;
   logic [IDX_W-1:0]  rp_ff;
   logic              loaded_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  base_ff;
   logic [IDX_W-1:0]  sw_a_ff;
   logic [IDX_W-1:0]  sw_b_ff;
   logic [ID_W-1:0]   hold_ff;
   logic [ID_W-1:0]   rd_data_ff;
   logic [ID_W-1:0]   res_id_ff;
   logic [STAT_W-1:0] res_stat_ff;
   logic              rsp_valid_ff;
   sid_rsp_type       rsp_data_ff;
   logic [ID_W-1:0]   id_table_ff [TABLE_SIZE];

   logic              accept;
   logic              launch;
   logic [IDX_W-1:0]  half;
   logic [IDX_W-1:0]  base_in;
   logic [ID_W-1:0]   size;
   logic [ID_W-1:0]   n_last;
   logic [ID_W-1:0]   rp_next;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ID_W-1:0]   wr_data;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE);

   // lanes run only for items that go on to the divide phase
   assign launch = accept && loaded_ff &&
                   ((req_data.cmd == CMD_DRAW) ||
                    ((req_data.cmd == CMD_SHUFFLE) && (sp_ff != '0)));

   // draw swaps land in the half that the read position is not in
   assign half    = id_count[ID_W-1:1];
   assign base_in = (rp_ff < half) ? half : '0;
   assign size    = (rp_ff < half) ? (id_count - {1'b0, half}) : {1'b0, half};
   assign n_last  = id_count - 1'b1;
   assign rp_next = {1'b0, rp_ff} + 1'b1;

   always_comb begin
      rem_a_cmd.start    = launch;
      rem_a_cmd.dividend = req_data.rand_a;
      rem_a_cmd.divisor  = (req_data.cmd == CMD_SHUFFLE) ? {1'b0, sp_ff} : size;
      rem_b_cmd.start    = launch;
      rem_b_cmd.dividend = req_data.rand_b;
      rem_b_cmd.divisor  = size;
      rem_c_cmd.start    = launch;
      rem_c_cmd.dividend = {{(RAND_W-ID_W){1'b0}}, rp_next};
      rem_c_cmd.divisor  = id_count;
   end

   always_comb begin
      case (state_ff)
         ST_SW_RA: rd_addr = sw_a_ff;
         ST_SW_RB: rd_addr = sw_b_ff;
         default:  rd_addr = rp_ff;
      endcase
      wr_en   = (state_ff == ST_FILL) || (state_ff == ST_SW_WA) || (state_ff == ST_SW_WB);
      case (state_ff)
         ST_FILL: begin
            wr_addr = idx_ff;
            wr_data = {1'b0, idx_ff} + 1'b1;
         end
         ST_SW_WA: begin
            wr_addr = sw_a_ff;
            wr_data = rd_data_ff;
         end
         default: begin
            wr_addr = sw_b_ff;
            wr_data = hold_ff;
         end
      endcase
   end

   // table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_table_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= id_table_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         rp_ff        <= '0;
         loaded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_FINISH the output register is refilled below
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff      <= req_data.cmd;
                  base_ff     <= base_in;
                  idx_ff      <= '0;
                  res_id_ff   <= '0;
                  res_stat_ff <= STAT_REFUSED;
                  case (req_data.cmd)
                     CMD_START:   state_ff <= ST_FILL;
                     CMD_SHUFFLE: state_ff <= (loaded_ff && sp_ff != '0) ? ST_DIVIDE : ST_FINISH;
                     CMD_DRAW:    state_ff <= loaded_ff ? ST_DIVIDE : ST_FINISH;
                     default:     state_ff <= ST_FINISH;
                  endcase
               end
            end
            ST_FILL: begin
               idx_ff <= idx_ff + 1'b1;
               if ({1'b0, idx_ff} == n_last) begin
                  sp_ff       <= n_last[IDX_W-1:0];
                  rp_ff       <= '0;
                  loaded_ff   <= 1'b1;
                  res_stat_ff <= STAT_STARTED;
                  state_ff    <= ST_FINISH;
               end
            end
            ST_DIVIDE: begin
               if (rem_done) begin
                  if (cmd_ff == CMD_SHUFFLE) begin
                     sw_a_ff     <= sp_ff;
                     sw_b_ff     <= rem_a;
                     sp_ff       <= sp_ff - 1'b1;
                     res_stat_ff <= STAT_SHUFFLED;
                  end else begin
                     sw_a_ff     <= rem_a + base_ff;
                     sw_b_ff     <= rem_b + base_ff;
                     rp_ff       <= rem_c;
                     res_id_ff   <= rd_data_ff;   // entry at the read position
                     res_stat_ff <= STAT_DRAWN;
                  end
                  state_ff <= ST_SW_RA;
               end
            end
            ST_SW_RA: state_ff <= ST_SW_RB;
            ST_SW_RB: begin
               hold_ff  <= rd_data_ff;
               state_ff <= ST_SW_WA;
            end
            ST_SW_WA: state_ff <= ST_SW_WB;
            ST_SW_WB: state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_data_ff.id_value <= res_id_ff;
                  rsp_data_ff.status   <= res_stat_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted item did not start work");

   a_id_only_on_draw: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != STAT_DRAWN) |-> rsp_data_ff.id_value == '0)
      else $error("nonzero id on a non-draw result");

   a_loaded_sticks: assert property (@(posedge clock) disable iff (reset)
      loaded_ff |=> loaded_ff)
      else $error("loaded flag dropped");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      rem_done |-> state_ff == ST_DIVIDE)
      else $error("remainder finished outside divide phase");

endmodule

`default_nettype wire

### rtl/shuffled_id_dispenser_unit.sv
// Top level of the shuffled ID dispenser: count register, three serial remainder
// lanes and the sequencer with the identifier table. Depends on sid_pkg, sid_rem_unit, sid_seq.
//
// Usage:
//  - req_* channel (valid/ready) carries one item: cmd, rand_a, rand_b.
//    cmd START fills the table with 1..N and arms the shuffle position at N-1,
//    SHUFFLE does one Sattolo swap, DRAW hands out the entry at the read position
//    and swaps two entries of the other half of the table.
//  - rsp_* channel (valid/ready) returns exactly one item per request:
//    id_value and status (drawn, start done, shuffle done, refused).
//  - csr_we/csr_wdata write N (clamped to 2..1024); write only while idle.
//  - Steps per item: START does one table write per cycle. SHUFFLE and DRAW run a
//    bit-serial remainder (one bit of the 31-bit random word per cycle, all lanes
//    in parallel), then two reads and two writes on the single table port for the
//    swap. Refusals go straight to the result, which turns valid as req_ready returns.
//  - One item at a time; a new item is accepted while the previous result still
//    sits in the output register, and finishing stalls only if that register is
//    still full when the next result is ready.
//  - Reset (synchronous) clears positions and the loaded flag and sets N to 1024.
//    The table itself is not cleared; draws before a START are refused.
`default_nettype none

module shuffled_id_dispenser_unit
   import sid_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_we,
   input  wire logic [ID_W-1:0] csr_wdata,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire sid_req_type     req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output sid_rsp_type          rsp_data
);

   localparam logic [ID_W-1:0] N_MIN = ID_W'(2);
   localparam logic [ID_W-1:0] N_MAX = ID_W'(TABLE_SIZE);

   logic [ID_W-1:0]  id_count_ff;
   logic [ID_W-1:0]  n_live;

   rem_cmd_type      rem_a_cmd;
   rem_cmd_type      rem_b_cmd;
   rem_cmd_type      rem_c_cmd;
   logic             done_a;
   logic             done_b;
   logic             done_c;
   logic [IDX_W-1:0] rem_a;
   logic [IDX_W-1:0] rem_b;
   logic [IDX_W-1:0] rem_c;

   // count register; the clamp is applied live on every command
   always_ff @(posedge clock) begin
      if (reset) begin
         id_count_ff <= N_MAX;
      end else if (csr_we) begin
         id_count_ff <= csr_wdata;
      end
   end

   assign n_live = (id_count_ff < N_MIN) ? N_MIN :
                   (id_count_ff > N_MAX) ? N_MAX : id_count_ff;

   // lane A: shuffle index or first draw index; lane B: second draw index;
   // lane C: next read position mod N
   sid_rem_unit u_rem_a (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rem_a_cmd),
      .done      (done_a),
      .remainder (rem_a)
   );

   sid_rem_unit u_rem_b (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rem_b_cmd),
      .done      (done_b),
      .remainder (rem_b)
   );

   sid_rem_unit u_rem_c (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rem_c_cmd),
      .done      (done_c),
      .remainder (rem_c)
   );

   // lanes launch together and run the same step count
   sid_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .id_count  (n_live),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .rem_a_cmd (rem_a_cmd),
      .rem_b_cmd (rem_b_cmd),
      .rem_c_cmd (rem_c_cmd),
      .rem_done  (done_a && done_b && done_c),
      .rem_a     (rem_a),
      .rem_b     (rem_b),
      .rem_c     (rem_c)
   );

endmodule

`default_nettype wire
